@@ src/ddpm_pkg.sv @@
package ddpm_pkg;

  localparam int unsigned CmdW   = 8;
  localparam int unsigned MagW   = 7;
  localparam int unsigned SplitW = 7;
  localparam int unsigned TrimW  = 5;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 7;
  localparam int unsigned ProdW  = 14;

  localparam logic signed [CmdW-1:0] CmdMax = 8'sd100;
  localparam logic signed [CmdW-1:0] CmdMin = -8'sd100;
  localparam logic [MagW-1:0]        FullScale = 7'd100;
  localparam logic [MagW-1:0]        TickLast = 7'd100;

  // floor(p/100) = (p*5243) >> 19, exact for p <= 10000
  localparam logic [12:0]    Recip100 = 13'd5243;
  localparam int unsigned    RecipShift = 19;

  localparam logic [SplitW-1:0] SplitReset = 7'd25;
  localparam logic [TrimW-1:0]  TrimLowReset = 5'd18;
  localparam logic [TrimW-1:0]  TrimHighReset = 5'd19;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TRIM_SPLIT = 2'd0,
    REG_TRIM_LOW   = 2'd1,
    REG_TRIM_HIGH  = 2'd2,
    REG_UNUSED     = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_LEFT     = 3'd1,
    MODE_RIGHT    = 3'd2,
    MODE_STRAIGHT = 3'd3,
    MODE_BACKWARD = 3'd4
  } mode_t;

  typedef struct packed {
    logic rdir;
    logic rpwm;
    logic ldir;
    logic lpwm;
  } pins_t;

  // mixer result toward the top level
  typedef struct packed {
    logic signed [CmdW-1:0] x;
    logic signed [CmdW-1:0] y;
    logic [MagW-1:0]        ay;
    logic [MagW-1:0]        left_duty;
    logic [MagW-1:0]        right_duty;
  } mix_t;

endpackage

@@ src/ddpm_mix.sv @@
module ddpm_mix (
  input  logic signed [7:0] x_raw,
  input  logic signed [7:0] y_raw,
  output ddpm_pkg::mix_t    mix
);
  import ddpm_pkg::*;

  logic signed [CmdW-1:0] x_c;
  logic signed [CmdW-1:0] y_c;
  logic [CmdW-1:0]        x_neg;
  logic [CmdW-1:0]        y_neg;
  logic [MagW-1:0]        ax;
  logic [MagW-1:0]        ay;
  logic [ProdW-1:0]       prod;
  logic [ProdW+12:0]      scaled;
  logic [MagW-1:0]        inner;

  always_comb begin
    if (x_raw > CmdMax)      x_c = CmdMax;
    else if (x_raw < CmdMin) x_c = CmdMin;
    else                     x_c = x_raw;
    if (y_raw > CmdMax)      y_c = CmdMax;
    else if (y_raw < CmdMin) y_c = CmdMin;
    else                     y_c = y_raw;
  end

  assign x_neg = -x_c;
  assign y_neg = -y_c;
  assign ax = x_c[CmdW-1] ? x_neg[MagW-1:0] : x_c[MagW-1:0];
  assign ay = y_c[CmdW-1] ? y_neg[MagW-1:0] : y_c[MagW-1:0];

  // inner wheel: (100-|x|)*|y|/100, truncated
  assign prod   = ProdW'(FullScale - ax) * ProdW'(ay);
  assign scaled = (ProdW+13)'(prod) * (ProdW+13)'(Recip100);
  assign inner  = scaled[RecipShift +: MagW];

  always_comb begin
    mix.x  = x_c;
    mix.y  = y_c;
    mix.ay = ay;
    if (!x_c[CmdW-1]) begin
      mix.left_duty  = ay;
      mix.right_duty = inner;
    end else begin
      mix.left_duty  = inner;
      mix.right_duty = ay;
    end
  end

endmodule

@@ src/differential_drive_pwm_mixer_top.sv @@
// Each accepted item's result is registered and shows on the out_ ports in the next cycle.
// Throughput: one item per cycle; the only stall comes from out_stall on a
//   result that is still waiting, set by the single result register.
// Reset (rst_n low, synchronous): pins low, mode idle, duties, trim, counter
//   and last command zero; trim_split 25, trim_low 18, trim_high 19.
module differential_drive_pwm_mixer_top (
  input  logic                         clk,
  input  logic                         rst_n,
  // item channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_req_type,
  input  logic signed [7:0]            in_x_cmd,
  input  logic signed [7:0]            in_y_cmd,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_left_pwm_pin,
  output logic                         out_left_dir_pin,
  output logic                         out_right_pwm_pin,
  output logic                         out_right_dir_pin,
  output logic [2:0]                   out_move_mode,
  // register writes
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ddpm_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [ddpm_pkg::CfgDataW-1:0] cfg_data
);
  import ddpm_pkg::*;

  // config registers
  logic [SplitW-1:0] trim_split_r;
  logic [TrimW-1:0]  trim_low_r;
  logic [TrimW-1:0]  trim_high_r;

  // block state; pins and mode double as the result payload, since they
  // only move when an item is accepted and so hold while out is stalled
  logic [MagW-1:0]        tick_count_r, tick_count_nxt;
  logic [MagW-1:0]        left_duty_r, left_duty_nxt;
  logic [MagW-1:0]        right_duty_r, right_duty_nxt;
  logic [TrimW-1:0]       right_trim_r, right_trim_nxt;
  logic                   speed_neg_r, speed_neg_nxt;
  logic signed [CmdW-1:0] last_x_r, last_x_nxt;
  logic signed [CmdW-1:0] last_y_r, last_y_nxt;
  mode_t                  mode_r, mode_nxt;
  pins_t                  pins_r, pins_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic      in_accept;
  mix_t      mix;
  logic [MagW-1:0] tick_cur;
  logic      left_off;
  logic      right_off;
  logic [11:0] tick_x20;
  logic [11:0] right_lim;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trim_split_r <= SplitReset;
      trim_low_r   <= TrimLowReset;
      trim_high_r  <= TrimHighReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TRIM_SPLIT: trim_split_r <= cfg_data[SplitW-1:0];
        REG_TRIM_LOW:   trim_low_r   <= cfg_data[TrimW-1:0];
        REG_TRIM_HIGH:  trim_high_r  <= cfg_data[TrimW-1:0];
        REG_UNUSED:     ;
      endcase
    end
  end

  ddpm_mix u_mix (
    .x_raw (in_x_cmd),
    .y_raw (in_y_cmd),
    .mix   (mix)
  );

  // tick path: counter wraps past 100 before the compare
  assign tick_cur  = (tick_count_r > TickLast) ? '0 : tick_count_r;
  assign left_off  = tick_cur > left_duty_r;
  assign tick_x20  = {1'b0, tick_cur, 4'b0} + {3'b0, tick_cur, 2'b0};
  assign right_lim = 12'(right_duty_r) * 12'(right_trim_r);
  assign right_off = tick_x20 > right_lim;

  always_comb begin
    tick_count_nxt = tick_count_r;
    left_duty_nxt  = left_duty_r;
    right_duty_nxt = right_duty_r;
    right_trim_nxt = right_trim_r;
    speed_neg_nxt  = speed_neg_r;
    last_x_nxt     = last_x_r;
    last_y_nxt     = last_y_r;
    mode_nxt       = mode_r;
    pins_nxt       = pins_r;
    out_valid_nxt  = out_valid_r && out_stall;

    if (in_accept) begin
      out_valid_nxt = 1'b1;
      if (in_req_type) begin
        // inverted polarity while backing up
        pins_nxt.lpwm  = left_off ^ ~speed_neg_r;
        pins_nxt.rpwm  = right_off ^ ~speed_neg_r;
        tick_count_nxt = tick_cur + 7'd1;
      end else begin
        // pins and mode move only on a changed command
        if (mix.x != last_x_r || mix.y != last_y_r) begin
          priority if (mix.x == 0 && mix.y == 0) begin
            mode_nxt = MODE_IDLE;
            pins_nxt = '0;
          end else if (mix.x != 0) begin
            mode_nxt = mix.x[CmdW-1] ? MODE_LEFT : MODE_RIGHT;
            if (mix.y > 0) begin
              pins_nxt.ldir = 1'b0;
              pins_nxt.rdir = 1'b0;
            end else begin
              // turning with zero or negative speed: take the reverse branch
              pins_nxt = '{rdir: 1'b1, rpwm: 1'b0, ldir: 1'b1, lpwm: 1'b0};
            end
          end else if (mix.y > 0) begin
            mode_nxt      = MODE_STRAIGHT;
            pins_nxt.ldir = 1'b0;
            pins_nxt.rdir = 1'b0;
          end else begin
            mode_nxt      = MODE_BACKWARD;
            pins_nxt.ldir = 1'b1;
            pins_nxt.rdir = 1'b1;
          end
        end
        speed_neg_nxt  = mix.y[CmdW-1];
        left_duty_nxt  = mix.left_duty;
        right_duty_nxt = mix.right_duty;
        right_trim_nxt = (mix.ay <= trim_split_r) ? trim_low_r : trim_high_r;
        last_x_nxt     = mix.x;
        last_y_nxt     = mix.y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r <= '0;
      left_duty_r  <= '0;
      right_duty_r <= '0;
      right_trim_r <= '0;
      speed_neg_r  <= 1'b0;
      last_x_r     <= '0;
      last_y_r     <= '0;
      mode_r       <= MODE_IDLE;
      pins_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      tick_count_r <= tick_count_nxt;
      left_duty_r  <= left_duty_nxt;
      right_duty_r <= right_duty_nxt;
      right_trim_r <= right_trim_nxt;
      speed_neg_r  <= speed_neg_nxt;
      last_x_r     <= last_x_nxt;
      last_y_r     <= last_y_nxt;
      mode_r       <= mode_nxt;
      pins_r       <= pins_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_left_pwm_pin  = pins_r.lpwm;
  assign out_left_dir_pin  = pins_r.ldir;
  assign out_right_pwm_pin = pins_r.rpwm;
  assign out_right_dir_pin = pins_r.rdir;
  assign out_move_mode     = mode_r;

  // counter never exceeds one past the top of the sweep
  a_tick_range: assert property (@(posedge clk) disable iff (!rst_n)
    tick_count_r <= TickLast + 7'd1)
    else $error("tick counter out of range");

  // every accepted item leaves a result behind
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid_r)
    else $error("accepted item produced no result");

  // straight drive keeps both wheels forward
  a_straight_dirs: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_STRAIGHT |-> !pins_r.ldir && !pins_r.rdir)
    else $error("straight mode with a reverse direction pin");

  // backward drive keeps both wheels reversed
  a_back_dirs: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_BACKWARD |-> pins_r.ldir && pins_r.rdir)
    else $error("backward mode with a forward direction pin");

endmodule
